// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the AX.25 address encoder checks
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ax25e check failed");

// next-cycle implication
`define AX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ax25e check failed");

`endif

// ----- rtl/core/ax25e_pkg.sv -----
// ---------------------------------------------------------------------------
// ax25e_pkg
// Shared constants and types of the AX.25 address encoder.
// ---------------------------------------------------------------------------
package ax25e_pkg;

	localparam int CALLSIGN_LEN = 6;
	localparam int CNT_W        = $clog2(CALLSIGN_LEN + 1);
	localparam int IDX_W        = (CALLSIGN_LEN > 1) ? $clog2(CALLSIGN_LEN) : 1;
	localparam int SSID_W       = 7;
	localparam int QDEPTH       = 2;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam int QCNT_W       = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_Z     = 8'h5a;
	localparam logic [SSID_W-1:0] SSID_MAX = SSID_W'(15);
	localparam logic [2:0] SSID_HEAD = 3'b011;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic                           err;
		logic [CNT_W-1:0]               count;
		logic [CALLSIGN_LEN-1:0][7:0]   callsign;
		logic [7:0]                     ssid_byte;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- rtl/core/ax25e_if.sv -----
// ---------------------------------------------------------------------------
// ax25e interfaces
// Valid/ready channels for address characters and encoded octets.
// ---------------------------------------------------------------------------
interface ax25e_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_address;
	logic       final_address;

	modport source (output valid, char_code, end_of_address, final_address, input ready);
	modport sink (input valid, char_code, end_of_address, final_address, output ready);
endinterface

interface ax25e_octet_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       error;
	logic       last;

	modport source (output valid, out_byte, error, last, input ready);
	modport sink (input valid, out_byte, error, last, output ready);
endinterface

// ----- rtl/core/ax25e_front.sv -----
// ---------------------------------------------------------------------------
// ax25e_front
// Character parser: checks address text and posts one job per address.
// ---------------------------------------------------------------------------
module ax25e_front (
	input  logic                 clk,
	input  logic                 arst_n,
	ax25e_char_if.sink           chars,
	input  ax25e_pkg::q_status_t qstat,
	output logic                 push,
	output ax25e_pkg::job_t      job
);

	logic [7:0]                           store_q [ax25e_pkg::CALLSIGN_LEN];
	logic [ax25e_pkg::CNT_W-1:0]          count_q, count_n;
	logic                                 in_ssid_q, in_ssid_n;
	logic [ax25e_pkg::SSID_W-1:0]         value_q, value_n;
	logic [1:0]                           digits_q, digits_n;
	logic                                 bad_q, bad_n;
	logic                                 wr_store;
	logic                                 digit, upper, colon, accept;
	logic [ax25e_pkg::SSID_W-1:0]         dval;

	assign chars.ready = !qstat.full;
	assign accept      = chars.valid && chars.ready;

	assign digit = (chars.char_code >= ax25e_pkg::CH_ZERO) && (chars.char_code <= ax25e_pkg::CH_NINE);
	assign upper = (chars.char_code >= ax25e_pkg::CH_A) && (chars.char_code <= ax25e_pkg::CH_Z);
	assign colon = (chars.char_code == ax25e_pkg::CH_COLON);
	assign dval  = ax25e_pkg::SSID_W'(chars.char_code - ax25e_pkg::CH_ZERO);

	always_comb begin
		count_n  = count_q;
		in_ssid_n = in_ssid_q;
		value_n  = value_q;
		digits_n = digits_q;
		bad_n    = bad_q;
		wr_store = 1'b0;
		if (!bad_q) begin
			if (!in_ssid_q) begin
				if (colon) begin
					in_ssid_n = 1'b1;
				end else if (digit || upper) begin
					if (count_q < ax25e_pkg::CNT_W'(ax25e_pkg::CALLSIGN_LEN)) begin
						wr_store = 1'b1;
						count_n  = count_q + ax25e_pkg::CNT_W'(1);
					end else begin
						bad_n = 1'b1;
					end
				end else begin
					bad_n = 1'b1;
				end
			end else begin
				if (digit && digits_q < 2'd2) begin
					value_n  = {value_q[ax25e_pkg::SSID_W-4:0], 3'b000}
						+ {value_q[ax25e_pkg::SSID_W-2:0], 1'b0} + dval;
					digits_n = digits_q + 2'd1;
				end else begin
					bad_n = 1'b1;
					if (digit) begin
						digits_n = 2'd3;
					end
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < ax25e_pkg::CALLSIGN_LEN; i++) begin
			job.callsign[i] = (wr_store && count_q == ax25e_pkg::CNT_W'(i))
				? chars.char_code : store_q[i];
		end
		job.count     = count_n;
		job.err       = bad_n || !in_ssid_n || (digits_n == 2'd0) || (value_n > ax25e_pkg::SSID_MAX);
		job.ssid_byte = {ax25e_pkg::SSID_HEAD, value_n[3:0], chars.final_address};
	end

	assign push = accept && chars.end_of_address;

	always_ff @(posedge clk) begin
		if (accept && wr_store) begin
			store_q[count_q[ax25e_pkg::IDX_W-1:0]] <= chars.char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			in_ssid_q <= 1'b0;
			value_q   <= '0;
			digits_q  <= '0;
			bad_q     <= 1'b0;
		end else if (accept) begin
			if (chars.end_of_address) begin
				count_q   <= '0;
				in_ssid_q <= 1'b0;
				value_q   <= '0;
				digits_q  <= '0;
				bad_q     <= 1'b0;
			end else begin
				count_q   <= count_n;
				in_ssid_q <= in_ssid_n;
				value_q   <= value_n;
				digits_q  <= digits_n;
				bad_q     <= bad_n;
			end
		end
	end

endmodule

// ----- rtl/core/ax25e_queue.sv -----
// ---------------------------------------------------------------------------
// ax25e_queue
// Short job queue between parser and octet emitter.
// ---------------------------------------------------------------------------
module ax25e_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ax25e_pkg::job_t      wr_job,
	input  logic                 pop,
	output ax25e_pkg::job_t      rd_job,
	output ax25e_pkg::q_status_t qstat
);

	ax25e_pkg::job_t                 mem_q [ax25e_pkg::QDEPTH];
	logic [ax25e_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [ax25e_pkg::QCNT_W-1:0]    cnt_q;

	assign qstat.full  = (cnt_q == ax25e_pkg::QCNT_W'(ax25e_pkg::QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign rd_job      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == ax25e_pkg::QPTR_W'(ax25e_pkg::QDEPTH - 1))
					? '0 : wr_ptr_q + ax25e_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == ax25e_pkg::QPTR_W'(ax25e_pkg::QDEPTH - 1))
					? '0 : rd_ptr_q + ax25e_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + ax25e_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - ax25e_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/ax25e_back.sv -----
// ---------------------------------------------------------------------------
// ax25e_back
// Octet emitter: walks the head job and drives the output register.
// ---------------------------------------------------------------------------
module ax25e_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ax25e_pkg::job_t      job,
	input  ax25e_pkg::q_status_t qstat,
	output logic                 pop,
	ax25e_octet_if.source        octets
);

	logic [ax25e_pkg::CNT_W-1:0] idx_q;
	logic                        valid_q;
	logic [7:0]                  byte_q;
	logic                        error_q, last_q;
	logic                        load, at_ssid;
	logic [7:0]                  ch, byte_n;
	logic                        error_n, last_n;

	assign load    = !qstat.empty && (!valid_q || octets.ready);
	assign at_ssid = (idx_q == ax25e_pkg::CNT_W'(ax25e_pkg::CALLSIGN_LEN));

	always_comb begin
		ch = (idx_q < job.count) ? job.callsign[idx_q[ax25e_pkg::IDX_W-1:0]]
			: ax25e_pkg::CH_SPACE;
		if (job.err) begin
			byte_n  = '0;
			error_n = 1'b1;
			last_n  = 1'b1;
		end else if (at_ssid) begin
			byte_n  = job.ssid_byte;
			error_n = 1'b0;
			last_n  = 1'b1;
		end else begin
			byte_n  = {ch[6:0], 1'b0};
			error_n = 1'b0;
			last_n  = 1'b0;
		end
	end

	assign pop = load && last_n;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= byte_n;
			error_q <= error_n;
			last_q  <= last_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last_n ? '0 : idx_q + ax25e_pkg::CNT_W'(1);
			end else if (octets.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign octets.valid    = valid_q;
	assign octets.out_byte = byte_q;
	assign octets.error    = error_q;
	assign octets.last     = last_q;

endmodule

// ----- rtl/core/ax25_address_encoder_core.sv -----
// ---------------------------------------------------------------------------
// ax25_address_encoder_core
// AX.25 address field encoder: CALL:SSID text in, address octets out.
//
// channel  dir  payload
// chars    in   char_code[7:0], end_of_address, final_address
// octets   out  out_byte[7:0], error, last
//
// One character is taken per cycle while the job queue has room.
// A valid address yields seven octets from the emitter, an invalid one a single error octet.
// With two jobs queued the parser stalls until the emitter retires one.
// Reset clears parser state, queue pointers and the output valid.
// ---------------------------------------------------------------------------
module ax25_address_encoder_core (
	input  logic           clk,
	input  logic           arst_n,
	ax25e_char_if.sink     chars,
	ax25e_octet_if.source  octets
);

	ax25e_pkg::job_t      wr_job, rd_job;
	ax25e_pkg::q_status_t qstat;
	logic                 push, pop;

	ax25e_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.qstat  (qstat),
		.push   (push),
		.job    (wr_job)
	);

	ax25e_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.qstat  (qstat)
	);

	ax25e_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (rd_job),
		.qstat  (qstat),
		.pop    (pop),
		.octets (octets)
	);

endmodule

// ----- rtl/core/ax25e_checker.sv -----
// ---------------------------------------------------------------------------
// ax25e_checker
// Port-level checks of the encoder output stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ax25e_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       error,
	input logic       last
);

	`AX_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(error) && $stable(last))
	`AX_ASSERT_NOW(a_err_form, clk, arst_n, out_valid && error, last && (out_byte == 8'h00))
	`AX_ASSERT_NOW(a_ssid_form, clk, arst_n, out_valid && last && !error, out_byte[7:5] == ax25e_pkg::SSID_HEAD)
	`AX_ASSERT_NEXT(a_run_no_err, clk, arst_n, out_valid && out_ready && !last, !(out_valid && error))

endmodule

bind ax25_address_encoder_core ax25e_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (octets.valid),
	.out_ready (octets.ready),
	.out_byte  (octets.out_byte),
	.error     (octets.error),
	.last      (octets.last)
);

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Testbench of ax25_address_encoder_core. Sends CALL:SSID address text one
// character per transfer and predicts the octets of every finished address
// from a shadow of the parser state. Each output transfer is checked field by
// field against the oldest predicted octet. Both sides idle at random unless calm.
// ---------------------------------------------------------------------------
module tb_top;

	typedef ax25e_pkg::byte_t text_t[$];

	typedef struct packed {
		ax25e_pkg::byte_t data;
		logic             err;
		logic             lst;
	} octet_t;

	typedef enum {
		ADDR_CLEAN,
		ADDR_LONG,
		ADDR_NO_COLON,
		ADDR_NO_DIGIT,
		ADDR_THREE_DIGITS,
		ADDR_BIG_SSID,
		ADDR_NOISE,
		ADDR_TWO_COLONS
	} addr_kind_t;

	logic clk;
	logic arst_n;

	ax25e_char_if  char_bus();
	ax25e_octet_if octet_bus();

	ax25_address_encoder_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (char_bus),
		.octets (octet_bus)
	);

	octet_t      octets_due[$];
	int          fail_count = 0;
	bit          calm = 0;
	int          sink_hold = 0;

	ax25e_pkg::byte_t cs_store[ax25e_pkg::CALLSIGN_LEN];
	logic [2:0]  cs_count = '0;
	logic        colon_seen = 1'b0;
	logic [6:0]  ssid_val = '0;
	logic [1:0]  ssid_cnt = '0;
	logic        addr_bad = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void encode_char(ax25e_pkg::byte_t c, logic eoa, logic fin);
		logic             is_digit;
		logic             is_upper;
		ax25e_pkg::byte_t ch;
		is_digit = (c >= ax25e_pkg::CH_ZERO) && (c <= ax25e_pkg::CH_NINE);
		is_upper = (c >= ax25e_pkg::CH_A) && (c <= ax25e_pkg::CH_Z);
		if (!addr_bad) begin
			if (!colon_seen) begin
				if (c == ax25e_pkg::CH_COLON) begin
					colon_seen = 1'b1;
				end else if (is_digit || is_upper) begin
					if (cs_count < ax25e_pkg::CALLSIGN_LEN) begin
						cs_store[cs_count] = c;
						cs_count = cs_count + 3'd1;
					end else begin
						addr_bad = 1'b1;
					end
				end else begin
					addr_bad = 1'b1;
				end
			end else if (is_digit && ssid_cnt < 2) begin
				ssid_val = 7'(ssid_val * 7'd10 + 7'(c - ax25e_pkg::CH_ZERO));
				ssid_cnt = ssid_cnt + 2'd1;
			end else begin
				addr_bad = 1'b1;
				if (is_digit)
					ssid_cnt = 2'd3;
			end
		end
		if (!eoa)
			return;
		if (addr_bad || !colon_seen || ssid_cnt == 0 || ssid_val > ax25e_pkg::SSID_MAX) begin
			octets_due.push_back('{8'h00, 1'b1, 1'b1});
		end else begin
			for (int k = 0; k < ax25e_pkg::CALLSIGN_LEN; k++) begin
				ch = (k < cs_count) ? cs_store[k] : ax25e_pkg::CH_SPACE;
				octets_due.push_back('{{ch[6:0], 1'b0}, 1'b0, 1'b0});
			end
			octets_due.push_back('{{ax25e_pkg::SSID_HEAD, ssid_val[3:0], fin}, 1'b0, 1'b1});
		end
		cs_count = '0;
		colon_seen = 1'b0;
		ssid_val = '0;
		ssid_cnt = '0;
		addr_bad = 1'b0;
	endfunction

	task automatic send_char(ax25e_pkg::byte_t c, logic eoa, logic fin);
		while (!calm && $urandom_range(0, 99) < 29) begin
			char_bus.valid <= 1'b0;
			@(posedge clk);
		end
		char_bus.valid <= 1'b1;
		char_bus.char_code <= c;
		char_bus.end_of_address <= eoa;
		char_bus.final_address <= fin;
		do @(negedge clk); while (char_bus.ready !== 1'b1);
		@(posedge clk);
		encode_char(c, eoa, fin);
	endtask

	task automatic send_seq(text_t s, logic fin);
		for (int i = 0; i < s.size(); i++) begin
			if (i == s.size() - 1)
				send_char(s[i], 1'b1, fin);
			else
				send_char(s[i], 1'b0, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic wait_drained();
		char_bus.valid <= 1'b0;
		@(posedge clk);
		while (octets_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic text_t to_chars(string s);
		text_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(ax25e_pkg::byte_t'(s[i]));
		return q;
	endfunction

	function automatic ax25e_pkg::byte_t callsign_char();
		int k;
		k = $urandom_range(0, 35);
		return (k < 26) ? ax25e_pkg::byte_t'(ax25e_pkg::CH_A + k)
			: ax25e_pkg::byte_t'(ax25e_pkg::CH_ZERO + k - 26);
	endfunction

	function automatic text_t random_address(addr_kind_t kind);
		text_t s;
		int    n;
		int    v;
		n = (kind == ADDR_LONG) ? ax25e_pkg::CALLSIGN_LEN + 1
			: $urandom_range(0, ax25e_pkg::CALLSIGN_LEN);
		for (int i = 0; i < n; i++)
			s.push_back(callsign_char());
		if (kind != ADDR_NO_COLON)
			s.push_back(ax25e_pkg::CH_COLON);
		if (kind == ADDR_TWO_COLONS)
			s.push_back(ax25e_pkg::CH_COLON);
		v = (kind == ADDR_BIG_SSID) ? $urandom_range(16, 99) : $urandom_range(0, 15);
		if (kind == ADDR_THREE_DIGITS)
			s.push_back(ax25e_pkg::byte_t'(ax25e_pkg::CH_ZERO + $urandom_range(0, 9)));
		if (kind != ADDR_NO_DIGIT) begin
			if (v >= 10 || kind == ADDR_THREE_DIGITS || $urandom_range(0, 1))
				s.push_back(ax25e_pkg::byte_t'(ax25e_pkg::CH_ZERO + v / 10));
			s.push_back(ax25e_pkg::byte_t'(ax25e_pkg::CH_ZERO + v % 10));
		end
		if (kind == ADDR_NOISE)
			s.insert($urandom_range(0, s.size()), ax25e_pkg::byte_t'($urandom_range(0, 255)));
		return s;
	endfunction

	task automatic send_random_addresses(int budget, int drain_pct);
		text_t      s;
		int         r;
		int         sent;
		addr_kind_t kind;
		sent = 0;
		while (sent < budget) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				kind = ADDR_LONG;
			else if (r < 8)
				kind = ADDR_NO_COLON;
			else if (r < 12)
				kind = ADDR_NO_DIGIT;
			else if (r < 18)
				kind = ADDR_THREE_DIGITS;
			else if (r < 26)
				kind = ADDR_BIG_SSID;
			else if (r < 36)
				kind = ADDR_NOISE;
			else if (r < 40)
				kind = ADDR_TWO_COLONS;
			else
				kind = ADDR_CLEAN;
			s = random_address(kind);
			send_seq(s, 1'($urandom_range(0, 1)));
			sent += s.size();
			if ($urandom_range(0, 99) < drain_pct)
				wait_drained();
		end
	endtask

	task automatic test_valid_forms();
		send_seq(to_chars(":0"), 1'b1);
		send_seq(to_chars("AZ:05"), 1'b0);
		wait_drained();
	endtask

	task automatic test_bad_chars();
		send_seq(to_chars("a"), 1'b0);
		send_char(8'h00, 1'b1, 1'b1);
		send_char(8'hff, 1'b1, 1'b0);
		wait_drained();
	endtask

	task automatic test_bad_ssid();
		send_seq(to_chars("Q:"), 1'b1);
		send_seq(to_chars(":1:"), 1'b0);
		send_seq(to_chars(":16"), 1'b1);
		send_seq(to_chars(":123"), 1'b0);
		wait_drained();
	endtask

	task automatic test_long_callsign();
		send_seq(to_chars("ABCDEFG"), 1'b1);
		wait_drained();
	endtask

	task automatic test_streaming();
		calm = 1;
		send_random_addresses(60, 0);
		wait_drained();
		calm = 0;
	endtask

	task automatic test_backpressure();
		sink_hold = 300;
		repeat (5)
			send_seq(random_address(ADDR_CLEAN), 1'($urandom_range(0, 1)));
		wait_drained();
	endtask

	task automatic test_random();
		send_random_addresses(150, 8);
		wait_drained();
	endtask

	initial begin
		octet_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				sink_hold--;
				octet_bus.ready <= 1'b0;
			end else begin
				octet_bus.ready <= calm || ($urandom_range(0, 99) >= 29);
			end
		end
	end

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(negedge clk) begin
		octet_t want;
		if (arst_n && octet_bus.valid === 1'b1 && octet_bus.ready === 1'b1) begin
			if (octets_due.size() == 0) begin
				$error("unexpected octet: out_byte=%0h error=%0b last=%0b",
					octet_bus.out_byte, octet_bus.error, octet_bus.last);
				fail_count++;
			end else begin
				want = octets_due.pop_front();
				check_field("out_byte", want.data, octet_bus.out_byte);
				check_field("error", 8'(want.err), 8'(octet_bus.error));
				check_field("last", 8'(want.lst), 8'(octet_bus.last));
			end
		end
	end

	initial begin
		#2000000;
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		char_bus.valid = 1'b0;
		char_bus.char_code = '0;
		char_bus.end_of_address = 1'b0;
		char_bus.final_address = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_valid_forms();
		test_bad_chars();
		test_bad_ssid();
		test_long_callsign();
		test_streaming();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && octets_due.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/ax25e_pkg.sv
rtl/core/ax25e_if.sv
rtl/core/ax25e_front.sv
rtl/core/ax25e_queue.sv
rtl/core/ax25e_back.sv
rtl/core/ax25_address_encoder_core.sv
rtl/core/ax25e_checker.sv
tb/tb_top.sv
